// ===== rtl/sbls_pkg.sv =====
// Shared constants and types for the stroke box, length and smoothing block.
package sbls_pkg;

    localparam int COORD_W_DEF  = 20;
    localparam int LENGTH_W_DEF = 32;

    localparam int TOL_W = 12;
    localparam logic [TOL_W-1:0] TOL_RESET = 12'd48;

    localparam int KIND_W = 2;
    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_MOVE = 2'd0;
    localparam kind_t KIND_QUAD = 2'd1;
    localparam kind_t KIND_NONE = 2'd2;

endpackage

// ===== rtl/stroke_bbox_length_smoother.sv =====
// Top level: stroke bounding box, serial arc length and quadratic smoothing.
//
//  channel | handshake               | words
//  --------+-------------------------+--------------------------------------------
//  in      | in_valid / in_stall     | point_x, point_y, stroke_start
//  out     | out_valid / out_stall   | box, stroke_length, segment_kind, control, end
//  cfg     | cfg_valid / cfg_ready   | min_travel
//
// Continuing point: prep, then the squarers, then the root, then done loads the result.
// Stroke start goes from prep straight to done. One point in flight; the next word is
// taken the cycle after the result loads, so a result waiting in the output register
// does not block input, but a stalled one holds the next item in done.
// Reset clears box, length, previous point and anchor to zero, tolerance to 48.
module stroke_bbox_length_smoother
    import sbls_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_W_DEF,
    parameter int LENGTH_WIDTH = LENGTH_W_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [COORD_WIDTH-1:0]  point_x,
    input  logic signed [COORD_WIDTH-1:0]  point_y,
    input  logic                           stroke_start,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [COORD_WIDTH-1:0]  box_min_x,
    output logic signed [COORD_WIDTH-1:0]  box_max_x,
    output logic signed [COORD_WIDTH-1:0]  box_min_y,
    output logic signed [COORD_WIDTH-1:0]  box_max_y,
    output logic [LENGTH_WIDTH-1:0]        stroke_length,
    output kind_t                          segment_kind,
    output logic signed [COORD_WIDTH-1:0]  control_x,
    output logic signed [COORD_WIDTH-1:0]  control_y,
    output logic signed [COORD_WIDTH-1:0]  end_x,
    output logic signed [COORD_WIDTH-1:0]  end_y,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [TOL_W-1:0]               min_travel
);

    localparam int C     = COORD_WIDTH;
    localparam int L     = LENGTH_WIDTH;
    localparam int N     = C + 1;
    localparam int SUM_W = ((L > N) ? L : N) + 1;
    localparam int CMP_W = (C > TOL_W) ? C : TOL_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_SQR  = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [TOL_W-1:0]        tol_reg;
    logic signed [C-1:0]     min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic [L-1:0]            length_reg;
    logic signed [C-1:0]     prev_x_reg, prev_y_reg, anchor_x_reg, anchor_y_reg;
    logic                    out_valid_reg;

    logic signed [C-1:0]     x_reg, y_reg;
    logic                    start_reg;
    kind_t                   res_kind_reg;
    logic signed [C-1:0]     res_cx_reg, res_cy_reg, res_ex_reg, res_ey_reg;

    logic signed [C-1:0]     o_min_x_reg, o_max_x_reg, o_min_y_reg, o_max_y_reg;
    logic [L-1:0]            o_length_reg;
    kind_t                   o_kind_reg;
    logic signed [C-1:0]     o_cx_reg, o_cy_reg, o_ex_reg, o_ey_reg;

    logic                    in_accept;
    logic                    out_load;
    logic                    sq_start;
    logic                    rt_start;
    logic                    sq_done_x, sq_done_y;
    logic                    rt_done;
    logic [2*C-1:0]          sq_x, sq_y;
    logic [2*C:0]            sq_sum;
    logic [N-1:0]            root;
    logic [SUM_W-1:0]        len_sum;
    logic [L-1:0]            len_sat;
    logic [C:0]              dx_raw, dy_raw, ax_raw, ay_raw;
    logic [C-1:0]            dx_mag, dy_mag, ax_mag, ay_mag;
    logic                    quad_hit;
    logic [C:0]              mid_x_sum, mid_y_sum;

    function automatic logic [C-1:0] abs_mag(input logic [C:0] d);
        logic [C:0] n;
        begin
            n = ~d + 1'b1;
            abs_mag = d[C] ? n[C-1:0] : d[C-1:0];
        end
    endfunction

    assign in_accept = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // distance to previous point and to anchor, sign extended by one bit
    assign dx_raw = {x_reg[C-1], x_reg} - {prev_x_reg[C-1], prev_x_reg};
    assign dy_raw = {y_reg[C-1], y_reg} - {prev_y_reg[C-1], prev_y_reg};
    assign ax_raw = {x_reg[C-1], x_reg} - {anchor_x_reg[C-1], anchor_x_reg};
    assign ay_raw = {y_reg[C-1], y_reg} - {anchor_y_reg[C-1], anchor_y_reg};
    assign dx_mag = abs_mag(dx_raw);
    assign dy_mag = abs_mag(dy_raw);
    assign ax_mag = abs_mag(ax_raw);
    assign ay_mag = abs_mag(ay_raw);

    assign quad_hit = (CMP_W'(ax_mag) >= CMP_W'(tol_reg))
                   || (CMP_W'(ay_mag) >= CMP_W'(tol_reg));

    // midpoint floors: drop the low bit of the widened sum
    assign mid_x_sum = {anchor_x_reg[C-1], anchor_x_reg} + {x_reg[C-1], x_reg};
    assign mid_y_sum = {anchor_y_reg[C-1], anchor_y_reg} + {y_reg[C-1], y_reg};

    assign sq_start = (state_reg == S_PREP) && !start_reg;
    assign rt_start = (state_reg == S_SQR) && sq_done_x && sq_done_y;
    assign sq_sum   = {1'b0, sq_x} + {1'b0, sq_y};

    assign len_sum = {{(SUM_W-L){1'b0}}, length_reg} + {{(SUM_W-N){1'b0}}, root};
    assign len_sat = (|len_sum[SUM_W-1:L]) ? {L{1'b1}} : len_sum[L-1:0];

    sbls_square #(.WIDTH(C)) u_sq_x
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sq_start),
        .mag    (dx_mag),
        .done   (sq_done_x),
        .square (sq_x)
    );

    sbls_square #(.WIDTH(C)) u_sq_y
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sq_start),
        .mag    (dy_mag),
        .done   (sq_done_y),
        .square (sq_y)
    );

    sbls_isqrt #(.STEPS(N)) u_root
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rt_start),
        .radicand ({1'b0, sq_sum}),
        .done     (rt_done),
        .root     (root)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                state_next = start_reg ? S_DONE : S_SQR;
            end
            S_SQR:
            begin
                if (sq_done_x && sq_done_y)
                    state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (rt_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tol_reg       <= TOL_RESET;
            min_x_reg     <= '0;
            max_x_reg     <= '0;
            min_y_reg     <= '0;
            max_y_reg     <= '0;
            length_reg    <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            anchor_x_reg  <= '0;
            anchor_y_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                tol_reg <= min_travel;

            if (state_reg == S_PREP)
            begin
                prev_x_reg <= x_reg;
                prev_y_reg <= y_reg;
                if (start_reg)
                begin
                    min_x_reg    <= x_reg;
                    max_x_reg    <= x_reg;
                    min_y_reg    <= y_reg;
                    max_y_reg    <= y_reg;
                    length_reg   <= '0;
                    anchor_x_reg <= x_reg;
                    anchor_y_reg <= y_reg;
                end
                else
                begin
                    if (x_reg < min_x_reg)
                        min_x_reg <= x_reg;
                    if (x_reg > max_x_reg)
                        max_x_reg <= x_reg;
                    if (y_reg < min_y_reg)
                        min_y_reg <= y_reg;
                    if (y_reg > max_y_reg)
                        max_y_reg <= y_reg;
                    if (quad_hit)
                    begin
                        anchor_x_reg <= x_reg;
                        anchor_y_reg <= y_reg;
                    end
                end
            end

            if ((state_reg == S_ROOT) && rt_done)
                length_reg <= len_sat;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_reg     <= point_x;
            y_reg     <= point_y;
            start_reg <= stroke_start;
        end

        if (state_reg == S_PREP)
        begin
            if (start_reg)
            begin
                res_kind_reg <= KIND_MOVE;
                res_cx_reg   <= x_reg;
                res_cy_reg   <= y_reg;
                res_ex_reg   <= '0;
                res_ey_reg   <= '0;
            end
            else if (quad_hit)
            begin
                res_kind_reg <= KIND_QUAD;
                res_cx_reg   <= anchor_x_reg;
                res_cy_reg   <= anchor_y_reg;
                res_ex_reg   <= mid_x_sum[C:1];
                res_ey_reg   <= mid_y_sum[C:1];
            end
            else
            begin
                res_kind_reg <= KIND_NONE;
                res_cx_reg   <= '0;
                res_cy_reg   <= '0;
                res_ex_reg   <= '0;
                res_ey_reg   <= '0;
            end
        end

        if (out_load)
        begin
            o_min_x_reg  <= min_x_reg;
            o_max_x_reg  <= max_x_reg;
            o_min_y_reg  <= min_y_reg;
            o_max_y_reg  <= max_y_reg;
            o_length_reg <= length_reg;
            o_kind_reg   <= res_kind_reg;
            o_cx_reg     <= res_cx_reg;
            o_cy_reg     <= res_cy_reg;
            o_ex_reg     <= res_ex_reg;
            o_ey_reg     <= res_ey_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign box_min_x     = o_min_x_reg;
    assign box_max_x     = o_max_x_reg;
    assign box_min_y     = o_min_y_reg;
    assign box_max_y     = o_max_y_reg;
    assign stroke_length = o_length_reg;
    assign segment_kind  = o_kind_reg;
    assign control_x     = o_cx_reg;
    assign control_y     = o_cy_reg;
    assign end_x         = o_ex_reg;
    assign end_y         = o_ey_reg;

endmodule

// ===== rtl/sbls_square.sv =====
// Bit-serial squarer: one multiplier bit per cycle, right-shifting product.
module sbls_square
    import sbls_pkg::*;
#(
    parameter int WIDTH = COORD_W_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WIDTH-1:0]     mag,
    output logic                 done,
    output logic [2*WIDTH-1:0]   square
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [WIDTH-1:0]   mcand_reg;
    logic [2*WIDTH-1:0] acc_reg;
    logic [WIDTH:0]     upper;

    // low half holds the remaining multiplier bits, high half the partial sum
    assign upper = {1'b0, acc_reg[2*WIDTH-1:WIDTH]}
                 + (acc_reg[0] ? {1'b0, mcand_reg} : {(WIDTH+1){1'b0}});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WIDTH - 1);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= mag;
            acc_reg   <= {{WIDTH{1'b0}}, mag};
        end
        else if (busy_reg)
        begin
            acc_reg <= {upper, acc_reg[WIDTH-1:1]};
        end
    end

    assign done   = done_reg;
    assign square = acc_reg;

endmodule

// ===== rtl/sbls_isqrt.sv =====
// Digit-serial restoring square root: one radicand bit pair per cycle.
module sbls_isqrt
    import sbls_pkg::*;
#(
    parameter int STEPS = COORD_W_DEF + 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [2*STEPS-1:0]   radicand,
    output logic                 done,
    output logic [STEPS-1:0]     root
);

    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int REM_W = STEPS + 2;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [2*STEPS-1:0] rad_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [STEPS-1:0]   root_reg;
    logic [REM_W+1:0]   rem_sh;
    logic [REM_W+1:0]   trial;
    logic [REM_W+1:0]   rem_sub;
    logic               fits;

    assign rem_sh  = {rem_reg, rad_reg[2*STEPS-1:2*STEPS-2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign fits    = (rem_sh >= trial);
    assign rem_sub = rem_sh - trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(STEPS - 1);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // remainder stays below 2*root+1, so REM_W bits hold it
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[2*STEPS-3:0], 2'b00};
            rem_reg  <= fits ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_reg <= {root_reg[STEPS-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== rtl/sbls_checker.sv =====
// Port-level checks for the stroke smoother, bound to the top level.
module sbls_checker
    import sbls_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_W_DEF,
    parameter int LENGTH_WIDTH = LENGTH_W_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic signed [COORD_WIDTH-1:0]  box_min_x,
    input  logic signed [COORD_WIDTH-1:0]  box_max_x,
    input  logic signed [COORD_WIDTH-1:0]  box_min_y,
    input  logic signed [COORD_WIDTH-1:0]  box_max_y,
    input  logic [LENGTH_WIDTH-1:0]        stroke_length,
    input  kind_t                          segment_kind,
    input  logic signed [COORD_WIDTH-1:0]  control_x,
    input  logic signed [COORD_WIDTH-1:0]  control_y,
    input  logic signed [COORD_WIDTH-1:0]  end_x,
    input  logic signed [COORD_WIDTH-1:0]  end_y
);

    // one point in flight: an accepted word blocks the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while previous word in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(stroke_length)
            && $stable(segment_kind) && $stable(end_x) && $stable(end_y))
        else $error("stalled result word changed");

    a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (box_min_x <= box_max_x) && (box_min_y <= box_max_y))
        else $error("bounding box inverted");

    // a move collapses the box onto its target and clears the length
    a_move_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (segment_kind == KIND_MOVE) |->
            (stroke_length == '0) && (box_min_x == control_x)
            && (box_max_x == control_x) && (box_min_y == control_y)
            && (box_max_y == control_y) && (end_x == '0) && (end_y == '0))
        else $error("move word inconsistent with box or length");

    a_none_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (segment_kind == KIND_NONE) |->
            (control_x == '0) && (control_y == '0) && (end_x == '0) && (end_y == '0))
        else $error("empty segment word carries points");

endmodule

bind stroke_bbox_length_smoother sbls_checker
#(
    .COORD_WIDTH  (COORD_WIDTH),
    .LENGTH_WIDTH (LENGTH_WIDTH)
)
u_sbls_checker (.*);

// ===== sim/stroke_bbox_length_smoother_tb.sv =====
// Self-checking testbench for the stroke box, length and smoothing block.
module stroke_bbox_length_smoother_tb
    import sbls_pkg::*;
();

    localparam int CW = COORD_W_DEF;
    localparam int LW = LENGTH_W_DEF;
    localparam longint COORD_MIN = -(longint'(1) << (CW - 1));
    localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;
    localparam longint unsigned LENGTH_TOP = (64'd1 << LW) - 1;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 2 * CW + 20;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct {
        coord_t        min_x;
        coord_t        max_x;
        coord_t        min_y;
        coord_t        max_y;
        logic [LW-1:0] length;
        kind_t         kind;
        coord_t        ctl_x;
        coord_t        ctl_y;
        coord_t        end_x;
        coord_t        end_y;
    } stroke_word_t;

    // Shadow of the stroke state plus the words still owed by the block.
    class stroke_board;
        logic [TOL_W-1:0] tolerance;
        longint lo_x, hi_x, lo_y, hi_y;
        longint last_x, last_y, anc_x, anc_y;
        longint unsigned arc;
        stroke_word_t due_words[$];
        int errors;
        int words_seen;

        function new();
            tolerance = TOL_RESET;
            lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
            last_x = 0; last_y = 0; anc_x = 0; anc_y = 0;
            arc = 0;
            errors = 0;
            words_seen = 0;
        endfunction

        // floor(sqrt(n)) built one result bit at a time, n < 2^42
        function longint unsigned root_floor(longint unsigned n);
            longint unsigned r, t;
            r = 0;
            for (int b = 21; b >= 0; b--)
            begin
                t = r | (64'd1 << b);
                if (t * t <= n)
                    r = t;
            end
            return r;
        endfunction

        function void take_point(coord_t px, coord_t py, logic start);
            longint x, y, dx, dy;
            stroke_word_t w;
            x = px;
            y = py;
            w.ctl_x = '0; w.ctl_y = '0; w.end_x = '0; w.end_y = '0;
            if (start)
            begin
                lo_x = x; hi_x = x; lo_y = y; hi_y = y;
                arc = 0;
                anc_x = x; anc_y = y;
                w.kind = KIND_MOVE;
                w.ctl_x = px;
                w.ctl_y = py;
            end
            else
            begin
                dx = x - last_x; if (dx < 0) dx = -dx;
                dy = y - last_y; if (dy < 0) dy = -dy;
                arc += root_floor(dx * dx + dy * dy);
                if (arc > LENGTH_TOP)
                    arc = LENGTH_TOP;
                if (x < lo_x) lo_x = x;
                if (x > hi_x) hi_x = x;
                if (y < lo_y) lo_y = y;
                if (y > hi_y) hi_y = y;
                dx = x - anc_x; if (dx < 0) dx = -dx;
                dy = y - anc_y; if (dy < 0) dy = -dy;
                if (dx >= longint'(tolerance) || dy >= longint'(tolerance))
                begin
                    w.kind  = KIND_QUAD;
                    w.ctl_x = coord_t'(anc_x);
                    w.ctl_y = coord_t'(anc_y);
                    // midpoint rounds toward minus infinity
                    w.end_x = coord_t'((anc_x + x) >>> 1);
                    w.end_y = coord_t'((anc_y + y) >>> 1);
                    anc_x = x;
                    anc_y = y;
                end
                else
                    w.kind = KIND_NONE;
            end
            last_x = x;
            last_y = y;
            w.min_x = coord_t'(lo_x);
            w.max_x = coord_t'(hi_x);
            w.min_y = coord_t'(lo_y);
            w.max_y = coord_t'(hi_y);
            w.length = arc[LW-1:0];
            due_words.push_back(w);
        endfunction

        task log_mismatch(string msg);
            errors++;
            $display("mismatch at word %0d: %s", words_seen, msg);
        endtask

        task check_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                log_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task match_result(stroke_word_t got);
            stroke_word_t want;
            words_seen++;
            if (due_words.size() == 0)
            begin
                log_mismatch("result word with no point outstanding");
                return;
            end
            want = due_words.pop_front();
            check_field("box_min_x", 64'(got.min_x), 64'(want.min_x));
            check_field("box_max_x", 64'(got.max_x), 64'(want.max_x));
            check_field("box_min_y", 64'(got.min_y), 64'(want.min_y));
            check_field("box_max_y", 64'(got.max_y), 64'(want.max_y));
            check_field("stroke_length", 64'(got.length), 64'(want.length));
            check_field("segment_kind", 64'(got.kind), 64'(want.kind));
            check_field("control_x", 64'(got.ctl_x), 64'(want.ctl_x));
            check_field("control_y", 64'(got.ctl_y), 64'(want.ctl_y));
            check_field("end_x", 64'(got.end_x), 64'(want.end_x));
            check_field("end_y", 64'(got.end_y), 64'(want.end_y));
        endtask
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    coord_t           point_x = '0;
    coord_t           point_y = '0;
    logic             stroke_start = 1'b0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    coord_t           box_min_x, box_max_x, box_min_y, box_max_y;
    logic [LW-1:0]    stroke_length;
    kind_t            segment_kind;
    coord_t           control_x, control_y, end_x, end_y;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [TOL_W-1:0] min_travel = TOL_RESET;

    int idle_pct = 0;
    int stall_left = 0;
    int cycle_count = 0;
    stroke_board board = new();

    stroke_bbox_length_smoother #(
        .COORD_WIDTH  (CW),
        .LENGTH_WIDTH (LW)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .point_x         (point_x),
        .point_y         (point_y),
        .stroke_start    (stroke_start),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .box_min_x       (box_min_x),
        .box_max_x       (box_max_x),
        .box_min_y       (box_min_y),
        .box_max_y       (box_max_y),
        .stroke_length   (stroke_length),
        .segment_kind    (segment_kind),
        .control_x       (control_x),
        .control_y       (control_y),
        .end_x           (end_x),
        .end_y           (end_y),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .min_travel      (min_travel)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: check accepted words, then pick the stall for the next cycle
    always @(posedge clk)
    begin : sample_out
        stroke_word_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.min_x  = box_min_x;
            got.max_x  = box_max_x;
            got.min_y  = box_min_y;
            got.max_y  = box_max_y;
            got.length = stroke_length;
            got.kind   = segment_kind;
            got.ctl_x  = control_x;
            got.ctl_y  = control_y;
            got.end_x  = end_x;
            got.end_y  = end_y;
            board.match_result(got);
        end
        if (stall_left == 0 && idle_pct != 0 && $urandom_range(99) < idle_pct)
            stall_left = $urandom_range(7, 1);
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    function automatic longint clamp(longint v);
        if (v < COORD_MIN)
            return COORD_MIN;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    function automatic longint rand_coord();
        coord_t c;
        case ($urandom_range(5))
            0: return COORD_MIN;
            1: return COORD_MAX;
            default:
            begin
                c = coord_t'($urandom);
                return c;
            end
        endcase
    endfunction

    task automatic send_point(longint x, longint y, bit start);
        int gap;
        if (idle_pct != 0 && $urandom_range(99) < 2 * idle_pct)
        begin
            gap = $urandom_range(7, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        point_x      <= coord_t'(x);
        point_y      <= coord_t'(y);
        stroke_start <= start;
        do @(posedge clk); while (in_stall !== 1'b0);
        board.take_point(coord_t'(x), coord_t'(y), start);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.due_words.size() != 0)
            @(posedge clk);
    endtask

    // tolerance may only change with no word in flight
    task automatic set_tolerance(logic [TOL_W-1:0] tol);
        drain();
        cfg_valid  <= 1'b1;
        min_travel <= tol;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        board.tolerance = tol;
        cfg_valid <= 1'b0;
    endtask

    // start word plus a walk whose step size is tied to the tolerance, random or full range
    task automatic random_stroke(int n_pts);
        longint x, y, span;
        x = rand_coord();
        y = rand_coord();
        case ($urandom_range(3))
            0: span = board.tolerance / 2 + 1;
            1: span = 2 * board.tolerance + 2;
            2: span = $urandom_range(4096, 1);
            default: span = longint'(1) << CW;
        endcase
        send_point(x, y, 1'b1);
        for (int i = 1; i < n_pts; i++)
        begin
            x = clamp(x + longint'($urandom_range(2 * span)) - span);
            y = clamp(y + longint'($urandom_range(2 * span)) - span);
            send_point(x, y, 1'b0);
        end
    endtask

    task automatic random_phase(int n_items, bit busy_sides);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            if (busy_sides)
                case ($urandom_range(2))
                    0: idle_pct = 0;
                    1: idle_pct = 10;
                    default: idle_pct = 30;
                endcase
            if ($urandom_range(9) == 0)
            begin
                // stray word, start flag at random
                send_point(rand_coord(), rand_coord(), 1'($urandom_range(1)));
                sent++;
            end
            else
            begin
                len = $urandom_range(40, 1);
                random_stroke(len);
                sent += len;
            end
        end
    endtask

    // corner to corner, the longest steps the coordinates allow
    task automatic long_haul(int n_pts);
        longint x, y;
        send_point(COORD_MIN + $urandom_range(15), COORD_MIN + $urandom_range(15), 1'b1);
        for (int i = 1; i < n_pts; i++)
        begin
            if (i % 2)
            begin
                x = COORD_MAX - $urandom_range(15);
                y = COORD_MAX - $urandom_range(15);
            end
            else
            begin
                x = COORD_MIN + $urandom_range(15);
                y = COORD_MIN + $urandom_range(15);
            end
            send_point(x, y, 1'b0);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_pct = 15;

        // tolerance still at its reset value; first word continues the zero stroke
        send_point(100, -50, 1'b0);
        send_point(0, 0, 1'b1);
        send_point(COORD_MAX, COORD_MAX, 1'b0);
        send_point(COORD_MIN, COORD_MIN, 1'b0);
        send_point(COORD_MIN, COORD_MAX, 1'b0);
        send_point(COORD_MIN + 18, COORD_MAX - 7, 1'b0);
        send_point(-1, -1, 1'b1);
        send_point(-50, 48, 1'b0);      // odd sums, midpoint floors
        send_point(-2, 48, 1'b0);       // travel equals tolerance
        send_point(45, 48, 1'b0);       // one short of tolerance
        send_point(45, 48, 1'b0);
        send_point(45, 48, 1'b1);
        send_point(0, 0, 1'b1);
        send_point(COORD_MAX, COORD_MIN, 1'b0);

        set_tolerance('0);
        send_point(0, 0, 1'b1);
        send_point(0, 0, 1'b0);
        send_point(-3, 5, 1'b0);

        set_tolerance({TOL_W{1'b1}});
        send_point(0, 0, 1'b1);
        send_point(4095, 0, 1'b0);
        send_point(8189, -4094, 1'b0);
        send_point(4095, -4095, 1'b0);
        send_point(COORD_MIN, COORD_MIN, 1'b0);

        set_tolerance(TOL_W'($urandom_range(4095)));
        random_phase(200, 1'b1);
        set_tolerance(12'd16);
        random_phase(200, 1'b1);
        set_tolerance(12'd1);
        random_phase(200, 1'b1);
        set_tolerance({TOL_W{1'b1}});
        random_phase(200, 1'b1);
        set_tolerance(TOL_W'($urandom_range(64)));
        random_phase(200, 1'b1);
        set_tolerance(TOL_RESET);
        random_phase(200, 1'b1);

        set_tolerance(TOL_W'($urandom_range(200)));
        idle_pct = 5;
        long_haul(470);

        // closing stretch with both sides running flat out
        set_tolerance(TOL_W'($urandom_range(100)));
        idle_pct = 0;
        random_phase(60, 1'b0);

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
